### rtl/core/pip_pkg.sv
// Shared types and constants of the point-in-polygon classifier.
package pip_pkg;

  // coordinate, difference and product widths
  localparam int CoordW = 32;
  localparam int TolW   = 20;
  localparam int DiffW  = 34;
  localparam int ProdW  = 2 * DiffW;
  localparam int SumW   = ProdW + 1;

  // request modes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;

  // result status codes
  localparam logic [2:0] ST_STORED = 3'd0;
  localparam logic [2:0] ST_DUP    = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_QUERY  = 3'd3;
  localparam logic [2:0] ST_CLEAR  = 3'd4;

  // multiplier operations, one product per edge step
  localparam logic [2:0] OP_LHSP = 3'd0;  // (py+e - yi) * ax
  localparam logic [2:0] OP_LHSM = 3'd1;  // (py-e - yi) * ax
  localparam logic [2:0] OP_RHS  = 3'd2;  // bx * ay
  localparam logic [2:0] OP_CR1  = 3'd3;  // ax * by
  localparam logic [2:0] OP_AXX  = 3'd4;
  localparam logic [2:0] OP_AYY  = 3'd5;
  localparam logic [2:0] OP_BXX  = 3'd6;
  localparam logic [2:0] OP_BYY  = 3'd7;
  localparam int NumOps = 8;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       start;
    logic       rd_en;
    logic       load_prev;
    logic       diff;
    logic       mul;
    logic [2:0] mul_op;
    logic       sum;
    logic       eval;
    logic       wr;
  } pip_cmd_t;

  // status from the datapath
  typedef struct packed {
    logic near;
    logic in_poly;
  } pip_stat_t;

endpackage

### rtl/core/pip_dp.sv
// Datapath: vertex memory, edge differences, shared multiplier and edge tests.
module pip_dp #(
  parameter int MAX_VERTICES = 32,
  parameter int AW = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pip_pkg::pip_cmd_t           cmd,
  input  logic [AW-1:0]               raddr,
  input  logic [AW-1:0]               waddr,
  input  logic signed [pip_pkg::CoordW-1:0] in_x,
  input  logic signed [pip_pkg::CoordW-1:0] in_y,
  input  logic [pip_pkg::TolW-1:0]    tol,
  output pip_pkg::pip_stat_t          stat
);

  localparam int CW = pip_pkg::CoordW;
  localparam int DW = pip_pkg::DiffW;
  localparam int PW = pip_pkg::ProdW;
  localparam int SW = pip_pkg::SumW;

  // vertex memory, {y, x}
  logic [2*CW-1:0] mem_r [MAX_VERTICES];
  logic [2*CW-1:0] rdata_r;

  // query point and tolerance
  logic signed [CW-1:0] px_r, py_r;
  logic signed [DW-1:0] pyp_r, pym_r, e_r;

  // previous vertex
  logic signed [CW-1:0] xj_r, yj_r;

  // edge differences
  logic signed [DW-1:0] ax_r, ay_r, bx_r, by_r, bp_r, bm_r;
  logic btwp_r, btwm_r;

  logic signed [PW-1:0] prod_r [pip_pkg::NumOps];
  logic signed [SW-1:0] cross_r, la_r, lb_r;

  logic rayp_r, raym_r, near_r, seg_r;

  // memory ports
  always_ff @(posedge clk) begin
    if (cmd.wr) mem_r[waddr] <= {py_r, px_r};
    if (cmd.rd_en) rdata_r <= mem_r[raddr];
  end

  // current vertex, extended
  logic signed [DW-1:0] xi, yi, xj, yj, px, py;
  assign xi = DW'(signed'(rdata_r[CW-1:0]));
  assign yi = DW'(signed'(rdata_r[2*CW-1:CW]));
  assign xj = DW'(xj_r);
  assign yj = DW'(yj_r);
  assign px = DW'(px_r);
  assign py = DW'(py_r);

  // difference stage
  logic signed [DW-1:0] dax, day, dbx, dby;
  logic dnear, dbtwp, dbtwm;
  always_comb begin
    dax   = xj - xi;
    day   = yj - yi;
    dbx   = px - xi;
    dby   = py - yi;
    dnear = (dbx >= -e_r) && (dbx <= e_r) && (dby >= -e_r) && (dby <= e_r);
    dbtwp = (yi < pyp_r && yj > pyp_r) || (yj < pyp_r && yi > pyp_r);
    dbtwm = (yi < pym_r && yj > pym_r) || (yj < pym_r && yi > pym_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px_r  <= in_x;
      py_r  <= in_y;
      e_r   <= DW'({1'b0, tol});
      pyp_r <= DW'(in_y) + DW'({1'b0, tol});
      pym_r <= DW'(in_y) - DW'({1'b0, tol});
    end
    if (cmd.load_prev) begin
      xj_r <= rdata_r[CW-1:0];
      yj_r <= rdata_r[2*CW-1:CW];
    end else if (cmd.eval) begin
      xj_r <= xi[CW-1:0];
      yj_r <= yi[CW-1:0];
    end
    if (cmd.diff) begin
      ax_r   <= dax;
      ay_r   <= day;
      bx_r   <= dbx;
      by_r   <= dby;
      bp_r   <= pyp_r - yi;
      bm_r   <= pym_r - yi;
      btwp_r <= dbtwp;
      btwm_r <= dbtwm;
    end
  end

  // shared multiplier, one product per step
  logic signed [DW-1:0] ma, mb;
  always_comb begin
    case (cmd.mul_op)
      pip_pkg::OP_LHSP: begin ma = bp_r; mb = ax_r; end
      pip_pkg::OP_LHSM: begin ma = bm_r; mb = ax_r; end
      pip_pkg::OP_RHS:  begin ma = bx_r; mb = ay_r; end
      pip_pkg::OP_CR1:  begin ma = ax_r; mb = by_r; end
      pip_pkg::OP_AXX:  begin ma = ax_r; mb = ax_r; end
      pip_pkg::OP_AYY:  begin ma = ay_r; mb = ay_r; end
      pip_pkg::OP_BXX:  begin ma = bx_r; mb = bx_r; end
      pip_pkg::OP_BYY:  begin ma = by_r; mb = by_r; end
      default:          begin ma = ax_r; mb = ax_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r[cmd.mul_op] <= ma * mb;
    if (cmd.sum) begin
      cross_r <= SW'(prod_r[pip_pkg::OP_CR1]) - SW'(prod_r[pip_pkg::OP_RHS]);
      la_r    <= SW'(prod_r[pip_pkg::OP_AXX]) + SW'(prod_r[pip_pkg::OP_AYY]);
      lb_r    <= SW'(prod_r[pip_pkg::OP_BXX]) + SW'(prod_r[pip_pkg::OP_BYY]);
    end
  end

  // edge decisions
  logic condp, condm, seg_ok, dirx_ok, diry_ok;
  logic signed [SW-1:0] e_w;
  always_comb begin
    e_w   = SW'(e_r);
    condp = (ay_r > 0 && prod_r[pip_pkg::OP_LHSP] < prod_r[pip_pkg::OP_RHS]) ||
            (ay_r < 0 && prod_r[pip_pkg::OP_LHSP] > prod_r[pip_pkg::OP_RHS]);
    condm = (ay_r > 0 && prod_r[pip_pkg::OP_LHSM] < prod_r[pip_pkg::OP_RHS]) ||
            (ay_r < 0 && prod_r[pip_pkg::OP_LHSM] > prod_r[pip_pkg::OP_RHS]);
    dirx_ok = !(ax_r != 0 && bx_r != 0 && (ax_r[DW-1] != bx_r[DW-1]));
    diry_ok = !(ay_r != 0 && by_r != 0 && (ay_r[DW-1] != by_r[DW-1]));
    seg_ok  = (cross_r <= e_w) && (cross_r >= -e_w) && dirx_ok && diry_ok &&
              (la_r >= lb_r);
  end

  // query flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rayp_r <= 1'b0;
      raym_r <= 1'b0;
      near_r <= 1'b0;
      seg_r  <= 1'b0;
    end else if (cmd.start) begin
      rayp_r <= 1'b0;
      raym_r <= 1'b0;
      near_r <= 1'b0;
      seg_r  <= 1'b0;
    end else begin
      if (cmd.diff && dnear) near_r <= 1'b1;
      if (cmd.eval) begin
        rayp_r <= rayp_r ^ (btwp_r & condp);
        raym_r <= raym_r ^ (btwm_r & condm);
        if (seg_ok) seg_r <= 1'b1;
      end
    end
  end

  assign stat.near    = near_r;
  assign stat.in_poly = rayp_r | raym_r | near_r | seg_r;

endmodule

### rtl/core/pip_ctrl.sv
// Controller: request sequencing, vertex walk, vertex count and result register.
module pip_ctrl #(
  parameter int MAX_VERTICES = 32,
  parameter int AW = 5,
  parameter int CNTW = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          in_mode,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [2:0]          out_status,
  output logic                out_inside,
  output logic [5:0]          out_count,
  output pip_pkg::pip_cmd_t   cmd,
  output logic [AW-1:0]       raddr,
  output logic [AW-1:0]       waddr,
  input  pip_pkg::pip_stat_t  stat
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RDPREV  = 3'd1;
  localparam logic [2:0] S_GETPREV = 3'd2;
  localparam logic [2:0] S_DIFF    = 3'd3;
  localparam logic [2:0] S_MUL     = 3'd4;
  localparam logic [2:0] S_SUM     = 3'd5;
  localparam logic [2:0] S_EVAL    = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  localparam logic [CNTW-1:0] MaxCnt = CNTW'(MAX_VERTICES);

  logic [2:0]      state_r, state_nxt;
  logic [1:0]      mode_r, mode_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [2:0]      step_r, step_nxt;
  logic            ov_r, ov_nxt;
  logic [2:0]      os_r, os_nxt;
  logic            oi_r, oi_nxt;
  logic [CNTW-1:0] last;

  assign last = cnt_r - CNTW'(1);

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    step_nxt  = step_r;
    ov_nxt    = ov_r;
    os_nxt    = os_r;
    oi_nxt    = oi_r;
    cmd       = '0;
    raddr     = '0;
    waddr     = cnt_r[AW-1:0];
    in_tready = (state_r == S_IDLE);

    if (ov_r && out_tready) ov_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          mode_nxt  = in_mode;
          if (in_mode == pip_pkg::MODE_CLEAR || cnt_r == '0) state_nxt = S_DONE;
          else state_nxt = S_RDPREV;
        end
      end
      // last vertex closes the polygon, so it is the first edge's start
      S_RDPREV: begin
        cmd.rd_en = 1'b1;
        raddr     = last[AW-1:0];
        state_nxt = S_GETPREV;
      end
      S_GETPREV: begin
        cmd.load_prev = 1'b1;
        cmd.rd_en     = 1'b1;
        raddr         = '0;
        idx_nxt       = '0;
        state_nxt     = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        step_nxt  = '0;
        state_nxt = mode_r[1] ? S_MUL : S_EVAL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        cmd.mul_op = step_r;
        step_nxt   = step_r + 3'd1;
        if (step_r == 3'(pip_pkg::NumOps - 1)) state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (idx_r == last[AW-1:0]) begin
          state_nxt = S_DONE;
        end else begin
          cmd.rd_en = 1'b1;
          raddr     = idx_r + AW'(1);
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_DIFF;
        end
      end
      S_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          oi_nxt    = 1'b0;
          state_nxt = S_IDLE;
          if (mode_r[1]) begin
            os_nxt = pip_pkg::ST_QUERY;
            oi_nxt = stat.in_poly;
          end else if (mode_r == pip_pkg::MODE_CLEAR) begin
            os_nxt  = pip_pkg::ST_CLEAR;
            cnt_nxt = '0;
          end else if (stat.near) begin
            os_nxt = pip_pkg::ST_DUP;
          end else if (cnt_r >= MaxCnt) begin
            os_nxt = pip_pkg::ST_FULL;
          end else begin
            cmd.wr  = 1'b1;
            os_nxt  = pip_pkg::ST_STORED;
            cnt_nxt = cnt_r + CNTW'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    idx_r  <= idx_nxt;
    step_r <= step_nxt;
    os_r   <= os_nxt;
    oi_r   <= oi_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_status = os_r;
  assign out_inside = oi_r;
  assign out_count  = 6'(cnt_r);

endmodule

### rtl/core/point_in_polygon_classifier.sv
// Top level of the point-in-polygon classifier: configuration register and wiring.
// Classifies Q16.16 points against a polygon of up to MAX_VERTICES stored vertices.
// A clear request, or a load or query against an empty polygon, goes straight to the result.
// Otherwise a load or query walks the N stored vertices: the query time is set
// by the single shared 34x34 multiplier, which forms eight products per edge,
// plus one read of the vertex memory per edge.
// The load time is set by the duplicate check, one vertex memory read per vertex.
// One request is worked on at a time; a new request is taken while the previous
// result waits on the output register. The tolerance register is at address 0.
module point_in_polygon_classifier #(
  parameter int MAX_VERTICES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // x_coord[31:0], y_coord[63:32]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // inside_res[0], vertex_count[6:1], zero[7]
  output logic [2:0]  out_tuser,  // status[2:0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam logic [2:0] ADDR_TOL = 3'd0;

  logic [pip_pkg::TolW-1:0] tol_r;
  pip_pkg::pip_cmd_t  cmd;
  pip_pkg::pip_stat_t stat;
  logic [AW-1:0]      raddr, waddr;
  logic               out_inside;
  logic [5:0]         out_count;

  // configuration register
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= pip_pkg::TolW'(66);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == ADDR_TOL) begin
      tol_r <= cfg_pwdata[pip_pkg::TolW-1:0];
    end
  end
  assign cfg_prdata = (cfg_paddr == ADDR_TOL) ? 32'(tol_r) : '0;

  pip_ctrl #(
    .MAX_VERTICES(MAX_VERTICES),
    .AW(AW),
    .CNTW(CNTW)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_mode(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_status(out_tuser),
    .out_inside(out_inside),
    .out_count(out_count),
    .cmd(cmd),
    .raddr(raddr),
    .waddr(waddr),
    .stat(stat)
  );

  pip_dp #(
    .MAX_VERTICES(MAX_VERTICES),
    .AW(AW)
  ) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .raddr(raddr),
    .waddr(waddr),
    .in_x(in_tdata[31:0]),
    .in_y(in_tdata[63:32]),
    .tol(tol_r),
    .stat(stat)
  );

  assign out_tdata = {1'b0, out_count, out_inside};

endmodule
